### src/restricted_deque_engine_unit_defines.svh
// Assertion macros shared by the deque engine RTL.
`ifndef RESTRICTED_DEQUE_ENGINE_UNIT_DEFINES_SVH
`define RESTRICTED_DEQUE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RDE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rde assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RDE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rde assertion failed");

`endif

### src/rde_pkg.sv
// Shared codes and types of the restricted deque engine.
`timescale 1ns / 1ps
package rde_pkg;

	localparam int OP_W  = 3;
	localparam int ST_W  = 3;
	localparam int CAP_W = 5;
	localparam int CFG_AW = 1;

	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

	localparam logic [ST_W-1:0] ST_OK         = 3'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW   = 3'd1;
	localparam logic [ST_W-1:0] ST_UNDERFLOW  = 3'd2;
	localparam logic [ST_W-1:0] ST_FORBIDDEN  = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY_LIST = 3'd4;

	localparam logic [CFG_AW-1:0] CFG_MODE = 1'b0;
	localparam logic [CFG_AW-1:0] CFG_CAP  = 1'b1;

	localparam logic MODE_IN_RESTRICT  = 1'b0;
	localparam logic MODE_OUT_RESTRICT = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	// what the back end does with a request
	typedef enum logic [1:0] {
		KIND_NOTE,
		KIND_WRITE,
		KIND_READ,
		KIND_LIST
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [ST_W-1:0]  status;
	} ctl_t;

endpackage

### src/restricted_deque_engine_unit.sv
// Restricted double-ended queue engine, top level.
//
// Requests enter on the s_* stream: s_tuser carries the opcode (push back,
// push front, pop front, pop back, list), s_tdata the word to push. Results
// leave on the m_* stream: m_tuser is the status, m_tdata the popped or
// listed word and the occupancy after the request, m_tlast marks the final
// result of a request. Mode and capacity are written through cfg_we,
// cfg_addr and cfg_wdata; the user must write them only while the engine
// is idle, which the block does not enforce. Push, pop and error requests
// give one result each; a listing gives one per held entry, as the back end
// reads the entry memory through its single read port once per cycle unless
// the output stalls. The front end accepts a new request every cycle while
// the two-entry request queue has room.
// Reset empties the queue, sets mode to input restricted and capacity to 16;
// entry memory is not cleared. When m_tready is low the output register
// holds, the back end stops, the request queue fills and s_tready drops.
`timescale 1ns / 1ps
module restricted_deque_engine_unit import rde_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32,
	localparam int OCC_W = $clog2(DEPTH + 1),
	localparam int IN_DW = ((DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_DW = ((DATA_WIDTH + OCC_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_AW-1:0]   cfg_addr,
	input  logic [CAP_W-1:0]    cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_DW-1:0]    s_tdata,   // push_value
	input  logic [OP_W-1:0]     s_tuser,   // opcode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_DW-1:0]   m_tdata,   // data_out, occupancy
	output logic [ST_W-1:0]     m_tuser,   // status
	output logic                m_tlast
);

	localparam int AW = $clog2(DEPTH);
	localparam int CMD_W = $bits(ctl_t) + AW + OCC_W + DATA_WIDTH;

	logic                         cmd_push;
	logic [CMD_W-1:0]             cmd_in;
	logic                         cmd_full;
	logic                         cmd_valid;
	logic [CMD_W-1:0]             cmd_out;
	logic                         cmd_pop;
	logic signed [DATA_WIDTH-1:0] data_out;
	logic [OCC_W-1:0]             occupancy;

	rde_front #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.opcode     (s_tuser),
		.push_value (s_tdata[DATA_WIDTH-1:0]),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in),
		.cmd_full   (cmd_full)
	);

	rde_cmdq #(.W(CMD_W)) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.valid  (cmd_valid),
		.dout   (cmd_out)
	);

	rde_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (m_tuser),
		.data_out  (data_out),
		.last_item (m_tlast),
		.occupancy (occupancy)
	);

	assign m_tdata = OUT_DW'({occupancy, data_out});

endmodule

### src/rde_front.sv
// Front end: config registers, pointer bookkeeping and request classification.
`timescale 1ns / 1ps
`include "restricted_deque_engine_unit_defines.svh"
module rde_front import rde_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW = $clog2(DEPTH),
	localparam int OCC_W = $clog2(DEPTH + 1),
	localparam int CMD_W = $bits(ctl_t) + AW + OCC_W + DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_AW-1:0]            cfg_addr,
	input  logic [CAP_W-1:0]             cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [OP_W-1:0]              opcode,
	input  logic signed [DATA_WIDTH-1:0] push_value,
	output logic                         cmd_push,
	output logic [CMD_W-1:0]             cmd,
	input  logic                         cmd_full
);

	localparam int CW = (OCC_W > CAP_W) ? OCC_W : CAP_W;
	localparam int SW = AW + 2;

	logic              mode_q;
	logic [CAP_W-1:0]  cap_q;
	logic [AW-1:0]     head_q;
	logic [OCC_W-1:0]  count_q;

	logic [CW-1:0]     cap_w;
	logic [CW-1:0]     cnt_w;
	logic [CW-1:0]     limit_w;
	logic              full;
	logic              empty;
	logic              forbidden;
	logic [AW-1:0]     head_inc;
	logic [AW-1:0]     head_dec;
	logic [SW-1:0]     tail_sum;

	ctl_t              ctl;
	logic [AW-1:0]     addr;
	logic [AW-1:0]     head_d;
	logic [OCC_W-1:0]  count_d;

	function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] v);
		logic [SW-1:0] d;
		d = v - SW'(DEPTH);
		return (v >= SW'(DEPTH)) ? d[AW-1:0] : v[AW-1:0];
	endfunction

	assign cap_w   = CW'(cap_q);
	assign cnt_w   = CW'(count_q);
	assign limit_w = (cap_w == '0) ? CW'(1) : ((cap_w > CW'(DEPTH)) ? CW'(DEPTH) : cap_w);
	assign full    = cnt_w >= limit_w;
	assign empty   = count_q == '0;

	assign forbidden = (opcode > OP_LIST) ||
		(opcode == OP_PUSH_FRONT && mode_q == MODE_IN_RESTRICT) ||
		(opcode == OP_POP_BACK && mode_q == MODE_OUT_RESTRICT);

	assign head_inc = wrap_idx(SW'(head_q) + SW'(1));
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign tail_sum = SW'(head_q) + SW'(count_q);

	always_comb begin
		ctl     = '{kind: KIND_NOTE, status: ST_OK};
		addr    = head_q;
		head_d  = head_q;
		count_d = count_q;
		if (forbidden) begin
			ctl.status = ST_FORBIDDEN;
		end else begin
			unique case (opcode) inside
				OP_PUSH_BACK, OP_PUSH_FRONT: begin
					if (full) begin
						ctl.status = ST_OVERFLOW;
					end else begin
						ctl.kind = KIND_WRITE;
						count_d  = count_q + OCC_W'(1);
						if (opcode == OP_PUSH_BACK) begin
							addr = wrap_idx(tail_sum);
						end else begin
							addr   = head_dec;
							head_d = head_dec;
						end
					end
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (empty) begin
						ctl.status = ST_UNDERFLOW;
					end else begin
						ctl.kind = KIND_READ;
						count_d  = count_q - OCC_W'(1);
						if (opcode == OP_POP_FRONT) begin
							head_d = head_inc;
						end else begin
							addr = wrap_idx(tail_sum - SW'(1));
						end
					end
				end
				default: begin
					if (empty) begin
						ctl.status = ST_EMPTY_LIST;
					end else begin
						ctl.kind = KIND_LIST;
					end
				end
			endcase
		end
	end

	assign in_ready = !cmd_full;
	assign cmd_push = in_valid && in_ready;
	assign cmd      = {ctl, addr, count_d, push_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IN_RESTRICT;
			cap_q   <= CAP_RESET;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_MODE: mode_q <= cfg_wdata[0];
					CFG_CAP:  cap_q  <= cfg_wdata;
					default:  ;
				endcase
			end
			if (cmd_push) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
		end
	end

	`RDE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= OCC_W'(DEPTH))
	`RDE_ASSERT_IMP(a_head_bound, 1'b1, head_q <= AW'(DEPTH - 1))

endmodule

### src/rde_cmdq.sv
// Short request queue between the front and back ends.
`timescale 1ns / 1ps
module rde_cmdq import rde_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] dout
);

	logic [W-1:0]         slot_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0]   wptr_q;
	logic [CMDQ_AW-1:0]   rptr_q;
	logic [CMDQ_AW:0]     cnt_q;
	logic                 do_pop;

	assign full   = cnt_q == (CMDQ_AW + 1)'(CMDQ_DEPTH);
	assign valid  = cnt_q != '0;
	assign dout   = slot_q[rptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + CMDQ_AW'(1);
			if (do_pop) rptr_q <= rptr_q + CMDQ_AW'(1);
			if (push && !do_pop) cnt_q <= cnt_q + (CMDQ_AW + 1)'(1);
			else if (!push && do_pop) cnt_q <= cnt_q - (CMDQ_AW + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= din;
	end

endmodule

### src/rde_back.sv
// Back end: entry memory, list sequencing and the output register.
`timescale 1ns / 1ps
`include "restricted_deque_engine_unit_defines.svh"
module rde_back import rde_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int DATA_WIDTH = 32,
	localparam int AW = $clog2(DEPTH),
	localparam int OCC_W = $clog2(DEPTH + 1),
	localparam int CMD_W = $bits(ctl_t) + AW + OCC_W + DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic [CMD_W-1:0]             cmd,
	output logic                         cmd_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ST_W-1:0]              status,
	output logic signed [DATA_WIDTH-1:0] data_out,
	output logic                         last_item,
	output logic [OCC_W-1:0]             occupancy
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	ctl_t                  c_ctl;
	logic [AW-1:0]         c_addr;
	logic [OCC_W-1:0]      c_occ;
	logic [DATA_WIDTH-1:0] c_data;

	logic                  out_free;
	logic                  s1_free;
	logic                  issue;
	logic                  is_list;
	logic                  last;
	logic [AW-1:0]         rd_addr;

	logic [OCC_W-1:0]      idx_q;
	logic [AW-1:0]         lptr_q;

	logic                  vld_s1;
	logic [DATA_WIDTH-1:0] rd_s1;
	logic [ST_W-1:0]       st_s1;
	logic [OCC_W-1:0]      occ_s1;
	logic                  last_s1;
	logic                  mem_s1;

	logic                  out_valid_q;
	logic [ST_W-1:0]       status_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  last_q;
	logic [OCC_W-1:0]      occ_q;

	assign {c_ctl, c_addr, c_occ, c_data} = cmd;

	assign out_free = !out_valid_q || out_ready;
	assign s1_free  = !vld_s1 || out_free;
	assign issue    = cmd_valid && s1_free;
	assign is_list  = c_ctl.kind == KIND_LIST;
	assign rd_addr  = (is_list && idx_q != '0) ? lptr_q : c_addr;
	assign last     = !is_list || (idx_q == c_occ - OCC_W'(1));
	assign cmd_pop  = issue && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (issue) vld_s1 <= 1'b1;
			else if (out_free) vld_s1 <= 1'b0;
			if (out_free) out_valid_q <= vld_s1;
			if (issue) idx_q <= last ? '0 : idx_q + OCC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (c_ctl.kind == KIND_WRITE) mem[c_addr] <= c_data;
			rd_s1   <= mem[rd_addr];
			lptr_q  <= (rd_addr == AW'(DEPTH - 1)) ? '0 : rd_addr + AW'(1);
			st_s1   <= c_ctl.status;
			occ_s1  <= c_occ;
			last_s1 <= last;
			mem_s1  <= (c_ctl.kind == KIND_READ) || is_list;
		end
		if (out_free && vld_s1) begin
			status_q <= st_s1;
			data_q   <= mem_s1 ? rd_s1 : '0;
			last_q   <= last_s1;
			occ_q    <= occ_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_q;
	assign last_item = last_q;
	assign occupancy = occ_q;

	`RDE_ASSERT_IMP(a_idx_in_list, idx_q != '0, cmd_valid && is_list && idx_q < c_occ)
	`RDE_ASSERT_NXT(a_idx_restart, issue && last, idx_q == '0)
	`RDE_ASSERT_IMP(a_err_zero, out_valid_q && status_q != ST_OK, data_q == '0)

endmodule
